### sv/sstq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_pkg
// shared constants and types for the sorted sleep timer queue
// ----------------------------------------------------------------------------
package sstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int ID_W        = 4;
  localparam int ENTRY_W     = TIME_W + ID_W;

  typedef enum logic [1:0] {
    KIND_SLEEP_OK   = 2'd0,
    KIND_SLEEP_FULL = 2'd1,
    KIND_WOKEN      = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

endpackage

### sv/sorted_sleep_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sleep_timer_queue
// rtos sleep queue: millisecond clock plus wake-time sorted list of tasks
// ----------------------------------------------------------------------------
// usage
//   in_ channel: func 0 is a sleep item (task_id, duration_ms), func 1 is a
//   one millisecond tick. out_ channel: kind, woken_task, now_ms, last.
//   the queue lives in one ram of {wake time, id}; it is kept as a circular
//   buffer so pops only move a head pointer. inserts shift the tail up one
//   entry a pass: read entry, compare, write it one slot higher.
//   a rejected sleep answers in the cycle after it is taken; an accepted sleep
//   reads each later entry on the ram read port, compares it and writes it one
//   slot higher on the write port (read and compare states), then writes the
//   new entry into the freed slot. a tick examines head entries in turn by
//   read, compare and emit states and wakes at most QUEUE_DEPTH tasks; each
//   woken item is held until the next head is compared, so last can be set.
//   one item in flight at a time. each result sits in an output register;
//   while the receiver stalls the engine waits, and in_stall stays high
//   until the item finishes and its final result has been taken.
//   reset clears the clock, the occupancy and the pointers; ram contents are
//   never used before being written.
// ----------------------------------------------------------------------------
module sorted_sleep_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [3:0]  in_task_id,
  input  logic [31:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_woken_task,
  output logic [31:0] out_now_ms,
  output logic        out_last
);

  localparam int IW = sstq_pkg::IDX_W;
  localparam int CW = sstq_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_POP_RD, S_POP_CMP, S_EMIT
  } state_t;

  state_t state_r;
  logic [CW-1:0] occ_r;
  logic [IW-1:0] head_r;
  logic [31:0]   clock_r;
  logic [31:0]   wake_r;
  logic [3:0]    id_r;      // request id, then the woken id being held
  logic [3:0]    nid_r;     // id of the head just popped
  logic [CW-1:0] pos_r;     // logical slot being examined (insert walks down)
  logic [CW-1:0] nwoke_r;
  logic          more_r;    // last compare popped a due head
  logic          have_r;    // a woken item is held back in id_r

  logic                          we;
  logic [IW-1:0]                 waddr, raddr;
  logic [sstq_pkg::ENTRY_W-1:0]  wdata, rdata;

  sstq_ram #(.WIDTH(sstq_pkg::ENTRY_W), .DEPTH(sstq_pkg::QUEUE_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // physical address of logical slot, wrapping at the depth
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h,
                                         input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(p);
    if (s >= (CW+1)'(sstq_pkg::QUEUE_DEPTH)) begin
      s = s - (CW+1)'(sstq_pkg::QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [31:0] r_wake;
  logic [3:0]  r_id;
  assign r_wake = rdata[sstq_pkg::ENTRY_W-1 -: 32];
  assign r_id   = rdata[3:0];

  logic accept;
  assign in_stall = (state_r != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  // output register free this cycle, and emit loads it this cycle
  logic out_free;
  logic emit_now;
  assign out_free = !out_valid || !out_stall;
  assign emit_now = (state_r == S_EMIT) && out_free && (have_r || !more_r);

  // read address: slot below pos when inserting, head when popping
  always_comb begin
    raddr = head_r;
    if (state_r == S_INS_RD) begin
      raddr = phys(head_r, pos_r - CW'(1));
    end
    we    = 1'b0;
    waddr = phys(head_r, pos_r);
    wdata = {wake_r, id_r};
    if (state_r == S_INS_CMP) begin
      we = 1'b1;
      if (r_wake > wake_r) begin
        wdata = rdata;   // shift this entry up one slot
      end
    end else if (state_r == S_INS_RD && pos_r == '0) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      head_r    <= '0;
      clock_r   <= '0;
      out_valid <= 1'b0;
      pos_r     <= '0;
      nwoke_r   <= '0;
      more_r    <= 1'b0;
      have_r    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            id_r <= in_task_id;
            if (in_func == sstq_pkg::FUNC_SLEEP) begin
              wake_r <= clock_r + in_duration_ms;
              if (occ_r >= CW'(sstq_pkg::QUEUE_DEPTH)) begin
                out_valid      <= 1'b1;
                out_kind       <= sstq_pkg::KIND_SLEEP_FULL;
                out_woken_task <= in_task_id;
                out_now_ms     <= clock_r;
                out_last       <= 1'b1;
              end else begin
                pos_r   <= occ_r;
                state_r <= S_INS_RD;
              end
            end else begin
              clock_r <= clock_r + 32'd1;
              nwoke_r <= '0;
              have_r  <= 1'b0;
              state_r <= S_POP_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos_r == '0) begin
            occ_r          <= occ_r + CW'(1);
            out_valid      <= 1'b1;
            out_kind       <= sstq_pkg::KIND_SLEEP_OK;
            out_woken_task <= id_r;
            out_now_ms     <= clock_r;
            out_last       <= 1'b1;
            state_r        <= S_IDLE;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (r_wake > wake_r) begin
            pos_r   <= pos_r - CW'(1);
            state_r <= S_INS_RD;
          end else begin
            occ_r          <= occ_r + CW'(1);
            out_valid      <= 1'b1;
            out_kind       <= sstq_pkg::KIND_SLEEP_OK;
            out_woken_task <= id_r;
            out_now_ms     <= clock_r;
            out_last       <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        S_POP_RD: begin
          state_r <= S_POP_CMP;
        end
        S_POP_CMP: begin
          // pop the head when due and the per-tick wake limit is not reached
          if (occ_r != '0 && r_wake <= clock_r
              && nwoke_r != CW'(sstq_pkg::QUEUE_DEPTH)) begin
            nid_r   <= r_id;
            head_r  <= phys(head_r, CW'(1));
            occ_r   <= occ_r - CW'(1);
            nwoke_r <= nwoke_r + CW'(1);
            more_r  <= 1'b1;
          end else begin
            more_r  <= 1'b0;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (have_r) begin
            // held item is last only when the compare just done found nothing
            if (out_free) begin
              out_valid      <= 1'b1;
              out_kind       <= sstq_pkg::KIND_WOKEN;
              out_woken_task <= id_r;
              out_now_ms     <= clock_r;
              out_last       <= !more_r;
              if (more_r) begin
                id_r    <= nid_r;
                state_r <= S_POP_RD;
              end else begin
                have_r  <= 1'b0;
                state_r <= S_IDLE;
              end
            end
          end else if (more_r) begin
            // first woken task: hold it until the next head is known
            id_r    <= nid_r;
            have_r  <= 1'b1;
            state_r <= S_POP_RD;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            out_kind       <= sstq_pkg::KIND_NONE;
            out_woken_task <= id_r;
            out_now_ms     <= clock_r;
            out_last       <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  property p_occ_bound;
    @(posedge clk) disable iff (!rst_n) occ_r <= CW'(sstq_pkg::QUEUE_DEPTH);
  endproperty
  a_occ_bound: assert property (p_occ_bound) else $error("occupancy overflow");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept) else $error("item taken while busy");

  a_tick_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func != sstq_pkg::FUNC_SLEEP) |=> clock_r == $past(clock_r) + 32'd1)
    else $error("tick did not advance clock");

endmodule

### sv/sstq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module sstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_sorted_sleep_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_sleep_timer_queue
// self-checking bench: sleep and tick items go in with random bursts and gaps,
// every result is checked against a local model of the sorted sleep queue
// ----------------------------------------------------------------------------
module tb_sorted_sleep_timer_queue;

  typedef struct packed {
    sstq_pkg::kind_t kind;
    logic [3:0]      task_id;
    logic [31:0]     now;
    logic            last;
  } wake_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [3:0]  in_task_id;
  logic [31:0] in_duration_ms;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [3:0]  out_woken_task;
  logic [31:0] out_now_ms;
  logic        out_last;

  // local copy of the queue state
  logic [31:0] q_wake [$];
  logic [3:0]  q_id [$];
  logic [31:0] clk_ms;
  wake_res_t   pending_res [$];

  int mismatches;
  int hold_cycles;   // long receiver hold-off, counted by the stall process
  bit idle_mode;     // no random gaps or stalls

  sorted_sleep_timer_queue i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_sorted_sleep_timer_queue NOT OK");
    $finish;
  end

  // model of one item: pushes every expected result
  task automatic predict_item(input logic func, input logic [3:0] id,
                              input logic [31:0] dur);
    logic [31:0] wake;
    int pos;
    int n;
    if (func == sstq_pkg::FUNC_SLEEP) begin
      wake = clk_ms + dur;
      if (q_wake.size() >= sstq_pkg::QUEUE_DEPTH) begin
        pending_res.push_back('{sstq_pkg::KIND_SLEEP_FULL, id, clk_ms, 1'b1});
      end else begin
        pos = 0;
        // equal wake times go after the existing ones
        while (pos < q_wake.size() && q_wake[pos] <= wake) pos++;
        q_wake.insert(pos, wake);
        q_id.insert(pos, id);
        pending_res.push_back('{sstq_pkg::KIND_SLEEP_OK, id, clk_ms, 1'b1});
      end
    end else begin
      clk_ms = clk_ms + 32'd1;
      n = 0;
      while (n < sstq_pkg::QUEUE_DEPTH && q_wake.size() > 0 && q_wake[0] <= clk_ms) begin
        pending_res.push_back('{sstq_pkg::KIND_WOKEN, q_id[0], clk_ms, 1'b0});
        void'(q_wake.pop_front());
        void'(q_id.pop_front());
        n++;
      end
      if (n == 0) pending_res.push_back('{sstq_pkg::KIND_NONE, id, clk_ms, 1'b1});
      else pending_res[pending_res.size()-1].last = 1'b1;
    end
  endtask

  // send one item, with a random gap before it unless gaps are off
  task automatic send_item(input logic func, input logic [3:0] id, input logic [31:0] dur);
    if (!idle_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_task_id     <= id;
    in_duration_ms <= dur;
    predict_item(func, id, dur);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // receiver: stall pattern of its own, plus an optional long hold-off
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (idle_mode) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  // checker of each accepted result
  always @(posedge clk) begin
    wake_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d id %0d", out_kind, out_woken_task);
      end else begin
        want = pending_res.pop_front();
        if (out_kind !== want.kind || out_woken_task !== want.task_id ||
            out_now_ms !== want.now || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp k%0d id%0d t%0d l%0d got k%0d id%0d t%0d l%0d",
                     want.kind, want.task_id, want.now, want.last,
                     out_kind, out_woken_task, out_now_ms, out_last);
        end
      end
    end
  end

  task automatic test_directed();
    int i;
    send_item(sstq_pkg::FUNC_TICK, 4'hF, 32'hFFFF_FFFF);  // tick on empty queue echoes id
    send_item(sstq_pkg::FUNC_SLEEP, 4'h0, 32'd0);         // already due at next tick
    send_item(sstq_pkg::FUNC_SLEEP, 4'hF, 32'd2);
    send_item(sstq_pkg::FUNC_SLEEP, 4'h3, 32'd2);         // equal wake time goes after
    send_item(sstq_pkg::FUNC_SLEEP, 4'h3, 32'd1);         // duplicate id
    send_item(sstq_pkg::FUNC_SLEEP, 4'h5, 32'hFFFF_FFFF); // wraps, wakes early
    send_item(sstq_pkg::FUNC_TICK, 4'h0, 32'd0);
    send_item(sstq_pkg::FUNC_TICK, 4'h0, 32'd0);
    send_item(sstq_pkg::FUNC_TICK, 4'hA, 32'h5555_AAAA);
    go_idle();
    // fill completely, then one rejected sleep
    for (i = 0; i < sstq_pkg::QUEUE_DEPTH; i++)
      send_item(sstq_pkg::FUNC_SLEEP, i[3:0], 32'd1);
    send_item(sstq_pkg::FUNC_SLEEP, 4'h9, 32'hAAAA_5555);
    send_item(sstq_pkg::FUNC_TICK, 4'h0, 32'd0);          // wakes all sixteen
    go_idle();
  endtask

  // well-formed mix: mostly short sleeps with ticks to wake them
  task automatic test_random(input int n);
    int i;
    logic [31:0] d;
    logic f;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       d = $urandom();
        1, 2, 3: d = $urandom_range(0, 3);
        default: d = $urandom_range(0, 12);
      endcase
      f = ($urandom_range(0, 9) < 4) ? sstq_pkg::FUNC_TICK : sstq_pkg::FUNC_SLEEP;
      send_item(f, 4'($urandom_range(0, 15)), d);
      if ($urandom_range(0, 40) == 0) idle_mode = ~idle_mode;
    end
    idle_mode = 1'b0;
    go_idle();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int i;
    hold_cycles = 400;
    for (i = 0; i < 20; i++)
      send_item(i[0] ? sstq_pkg::FUNC_TICK : sstq_pkg::FUNC_SLEEP,
                4'($urandom_range(0, 15)), $urandom_range(0, 3));
    go_idle();
  endtask

  initial begin
    mismatches     = 0;
    hold_cycles    = 0;
    idle_mode      = 1'b0;
    clk_ms         = 32'd0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = 1'b0;
    in_task_id     = 4'd0;
    in_duration_ms = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(130);
    test_backpressure();
    test_random(100);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("tb_sorted_sleep_timer_queue OK");
    end else begin
      $display("tb_sorted_sleep_timer_queue NOT OK");
    end
    $finish;
  end

endmodule
